[rtl/core/assert_macros.svh]
// Assertion macros used by the RTL files of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked property, skipped while reset is high.
`define JSP_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property, evaluated during reset as well.
`define JSP_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define JSP_ASSERT(name, clk, rst, prop, msg)
`define JSP_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

[rtl/core/jsp2p_pkg.sv]
// Package: characters, queue sizing, parse states and result beat type for the path converter.
`default_nettype none
package jsp2p_pkg;

   localparam logic [15:0] CH_DOLLAR = 16'h0024;
   localparam logic [15:0] CH_DOT    = 16'h002E;
   localparam logic [15:0] CH_OPEN   = 16'h005B;
   localparam logic [15:0] CH_CLOSE  = 16'h005D;
   localparam logic [15:0] CH_SLASH  = 16'h002F;
   localparam logic [15:0] CH_DQUOTE = 16'h0022;
   localparam logic [15:0] CH_SQUOTE = 16'h0027;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [2:0] {
      MODE_BETWEEN,
      MODE_PLAIN,
      MODE_BRACKET,
      MODE_QUOTE_START,
      MODE_QUOTED,
      MODE_AFTER_QUOTE,
      MODE_UNQUOTED
   } scan_mode_type;

   typedef struct packed {
      logic [15:0] out_char;
      logic        char_valid;
      logic        string_end;
      logic        run_last;
   } rsp_beat_type;

endpackage
`default_nettype wire

[rtl/core/jsonpath_segment_to_pointer_core.sv]
// Top level: JSONPath segment to JSON Pointer converter with result queue.
// Result beats are registered into the queue; rsp_ offers the oldest one held.
// Throughput: one input beat per cycle; each beat yields zero to two result beats
//    into a 4-entry queue, and req_ready stays high while at least two slots are free.
// Sustained rate is bound by the single rsp_ read port (one beat per cycle while rsp_ready is high).
// Reset (synchronous, active high) empties the queue and returns the parser to
//    the start of a new string.
`default_nettype none
`include "assert_macros.svh"
module jsonpath_segment_to_pointer_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_in_char,
   input  wire logic        req_in_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_out_char,
   output logic             rsp_char_valid,
   output logic             rsp_string_end,
   output logic             rsp_run_last
);
   import jsp2p_pkg::*;

   // parser state
   scan_mode_type mode_ff, mode_in;
   logic          quote_single_ff, quote_single_in;
   logic          at_first_ff, at_first_in;

   // result queue
   rsp_beat_type             queue_ff [QDEPTH];
   logic [QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]        count_ff, count_in;

   logic                     req_take;
   logic                     rsp_take;
   logic                     emit_slash;
   logic                     emit_char;
   logic [1:0]               push_n;
   rsp_beat_type             beat0;
   rsp_beat_type             beat1;
   logic [15:0]              quote_char;

   // Two free slots are needed since a beat may push two results.
   assign req_ready = (count_ff <= QCNT_W'(QDEPTH - 2));
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_take  = rsp_valid && rsp_ready;

   assign rsp_out_char   = queue_ff[rd_ptr_ff].out_char;
   assign rsp_char_valid = queue_ff[rd_ptr_ff].char_valid;
   assign rsp_string_end = queue_ff[rd_ptr_ff].string_end;
   assign rsp_run_last   = queue_ff[rd_ptr_ff].run_last;

   assign quote_char = quote_single_ff ? CH_SQUOTE : CH_DQUOTE;

   // Parse step: decide what this code unit emits and where the scan goes next.
   always_comb begin
      mode_in         = mode_ff;
      quote_single_in = quote_single_ff;
      emit_slash      = 1'b0;
      emit_char       = 1'b0;

      if (at_first_ff && req_in_char == CH_DOLLAR) begin
         // root mark: dropped
      end else begin
         unique case (mode_ff)
            MODE_BETWEEN, MODE_PLAIN: begin
               if (req_in_char == CH_DOT) begin
                  mode_in = MODE_BETWEEN;
               end else if (req_in_char == CH_OPEN) begin
                  mode_in = MODE_BRACKET;
               end else begin
                  emit_slash = (mode_ff == MODE_BETWEEN);
                  emit_char  = 1'b1;
                  mode_in    = MODE_PLAIN;
               end
            end
            MODE_BRACKET: begin
               if (req_in_char == CH_DQUOTE || req_in_char == CH_SQUOTE) begin
                  quote_single_in = (req_in_char == CH_SQUOTE);
                  mode_in         = MODE_QUOTE_START;
               end else if (req_in_char == CH_CLOSE) begin
                  mode_in = MODE_BETWEEN;
               end else begin
                  emit_slash = 1'b1;
                  emit_char  = 1'b1;
                  mode_in    = MODE_UNQUOTED;
               end
            end
            MODE_QUOTE_START, MODE_QUOTED: begin
               if (req_in_char == quote_char) begin
                  mode_in = MODE_AFTER_QUOTE;
               end else begin
                  emit_slash = (mode_ff == MODE_QUOTE_START);
                  emit_char  = 1'b1;
                  mode_in    = MODE_QUOTED;
               end
            end
            MODE_AFTER_QUOTE: begin
               // skip everything up to the closing bracket
               if (req_in_char == CH_CLOSE) begin
                  mode_in = MODE_BETWEEN;
               end
            end
            MODE_UNQUOTED: begin
               if (req_in_char == CH_CLOSE) begin
                  mode_in = MODE_BETWEEN;
               end else begin
                  emit_char = 1'b1;
               end
            end
            default: begin
               mode_in = MODE_BETWEEN;
            end
         endcase
      end

      at_first_in = 1'b0;
      if (req_in_last) begin
         // end of string: back to the start-of-string state
         mode_in         = MODE_BETWEEN;
         quote_single_in = 1'b0;
         at_first_in     = 1'b1;
      end
   end

   // Result beats for this input beat; tags go on the final one.
   always_comb begin
      beat0 = '0;
      beat1 = '0;
      if (emit_slash) begin
         beat0.out_char   = CH_SLASH;
         beat0.char_valid = 1'b1;
         beat1.out_char   = req_in_char;
         beat1.char_valid = 1'b1;
         beat1.string_end = req_in_last;
         beat1.run_last   = 1'b1;
         push_n           = 2'd2;
      end else if (emit_char) begin
         beat0.out_char   = req_in_char;
         beat0.char_valid = 1'b1;
         beat0.string_end = req_in_last;
         beat0.run_last   = 1'b1;
         push_n           = 2'd1;
      end else if (req_in_last) begin
         // bare end marker
         beat0.string_end = 1'b1;
         beat0.run_last   = 1'b1;
         push_n           = 2'd1;
      end else begin
         push_n = 2'd0;
      end
      if (!req_take) begin
         push_n = 2'd0;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(rsp_take);
      count_in  = count_ff + QCNT_W'(push_n) - QCNT_W'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_BETWEEN;
         quote_single_ff <= 1'b0;
         at_first_ff     <= 1'b1;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         count_ff        <= '0;
      end else begin
         if (req_take) begin
            mode_ff         <= mode_in;
            quote_single_ff <= quote_single_in;
            at_first_ff     <= at_first_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage: no reset, entries are read only once written.
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= beat0;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_ff + QPTR_W'(1)] <= beat1;
      end
   end

   `JSP_ASSERT(a_count_bound, clock, reset, count_ff <= QCNT_W'(QDEPTH), "queue count overflow")
   `JSP_ASSERT(a_end_is_run_last, clock, reset, (rsp_valid && rsp_string_end) |-> rsp_run_last, "string end beat lacks run_last")
   `JSP_ASSERT(a_last_resets_scan, clock, reset, (req_take && req_in_last) |=> (at_first_ff && mode_ff == MODE_BETWEEN && !quote_single_ff), "scan state not restarted after last beat")
   `JSP_ASSERT(a_first_cleared, clock, reset, (req_take && !req_in_last) |=> !at_first_ff, "first-unit flag stuck after a beat")

endmodule
`default_nettype wire
